[design/dnsq_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// DNS question parser package
// Shared constants, status codes and the queue entry passed from the
// byte classifier to the result formatter.
// ---------------------------------------------------------------------------
package dnsq_pkg;

   localparam int NAME_CAPACITY_DEFAULT = 256;
   localparam int QUEUE_DEPTH_DEFAULT   = 4;
   localparam int HEADER_BYTES          = 12;

   localparam logic [7:0] LABEL_PTR_MASK = 8'hC0;
   localparam logic [7:0] CHAR_DOT       = 8'h2E;
   localparam logic [7:0] CHAR_QUESTION  = 8'h3F;
   localparam logic [7:0] PRINT_LOW      = 8'h20;
   localparam logic [7:0] PRINT_HIGH     = 8'h7E;
   localparam logic [2:0] TAIL_BYTES     = 3'd4;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_SHORT   = 3'd1,
      ST_NOQ     = 3'd2,
      ST_COMP    = 3'd3,
      ST_OVERRUN = 3'd4,
      ST_EMPTY   = 3'd5,
      ST_NOTAIL  = 3'd6
   } dnsq_status_type;

   typedef enum logic {
      KIND_CHAR = 1'b0,
      KIND_DONE = 1'b1
   } dnsq_kind_type;

   // One accepted byte's work for the formatter
   typedef struct packed {
      logic            has_char;
      logic [7:0]      name_char;
      logic            has_done;
      dnsq_status_type status;
      logic [15:0]     query_type;
      logic [7:0]      name_length;
   } dnsq_entry_type;

endpackage

[design/dns_question_name_parser_core.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// DNS question name parser core
// Streams a DNS query packet in one byte per transfer and streams out the
// question name as characters, then one completion transfer per packet.
// ---------------------------------------------------------------------------
// Usage:
//   req_*  : one packet byte per transfer, req_tlast on the final byte.
//   rsp_*  : rsp_tuser = 0 is a name character, rsp_tuser = 1 the completion
//            carrying status, query type and name length, with rsp_tlast set.
//   Characters leave before the packet's status is known; drop them when the
//   completion reports an error.
//   A byte's result is written into the queue by the front end, then
//   loaded by the back end into the output register that drives rsp.
//   Throughput: one byte per cycle. A final byte that also yields a
//   character costs the back end two transfers; the four-entry queue
//   absorbs that and any rsp stall until it fills, then req_tready drops.
//   Reset: parser returns to the header phase, queue and output empty.
//   A stalled rsp holds its transfer unchanged until rsp_tready rises.
// ---------------------------------------------------------------------------
module dns_question_name_parser_core #(
   parameter int NAME_CAPACITY = dnsq_pkg::NAME_CAPACITY_DEFAULT,
   parameter int QUEUE_DEPTH   = dnsq_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // end_of_packet
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [7:0] name_char, [23:8] query_type,
                                    // [26:24] parse_status, [34:27] name_length,
                                    // [39:35] zero
   output logic        rsp_tuser,   // [0] item_kind
   output logic        rsp_tlast    // run_last
);
   import dnsq_pkg::*;

   logic           byte_xfer;
   logic           push;
   dnsq_entry_type push_entry;
   logic           pop;
   logic           q_full;
   logic           q_not_empty;
   dnsq_entry_type head_entry;

   logic [7:0]     out_char;
   logic [15:0]    out_qtype;
   logic [2:0]     out_status;
   logic [7:0]     out_length;

   // accept a byte whenever the queue has a free slot
   assign req_tready = !q_full;
   assign byte_xfer  = req_tvalid && req_tready;

   // front: classify each byte and track the parse
   dnsq_front #(
      .NAME_CAPACITY(NAME_CAPACITY)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .byte_valid   (byte_xfer),
      .data_byte    (req_tdata),
      .end_of_packet(req_tlast),
      .push         (push),
      .push_entry   (push_entry)
   );

   // queue: decouple parsing from result delivery
   dnsq_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_entry(push_entry),
      .pop       (pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head_entry(head_entry)
   );

   // back: format result transfers into the output register
   dnsq_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_valid(q_not_empty),
      .head_entry(head_entry),
      .pop       (pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_kind  (rsp_tuser),
      .out_char  (out_char),
      .out_qtype (out_qtype),
      .out_status(out_status),
      .out_length(out_length),
      .out_last  (rsp_tlast)
   );

   // pack result fields, lowest field first, zero fill to a whole byte
   assign rsp_tdata = {5'd0, out_length, out_status, out_qtype, out_char};

endmodule

[design/dnsq_front.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// DNS question parser front end
// Walks header, labels and type/class one byte per byte_valid cycle and
// pushes the resulting character and completion work into the queue.
// ---------------------------------------------------------------------------
module dnsq_front #(
   parameter int NAME_CAPACITY = 256
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    byte_valid,
   input  logic [7:0]              data_byte,
   input  logic                    end_of_packet,
   output logic                    push,
   output dnsq_pkg::dnsq_entry_type push_entry
);
   import dnsq_pkg::*;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_LENGTH,
      PH_LABEL,
      PH_TAIL,
      PH_DONE,
      PH_DRAIN
   } phase_type;

   localparam logic [8:0] CHAR_LIMIT = 9'(NAME_CAPACITY - 1);
   localparam logic [3:0] HDR_LAST   = 4'(HEADER_BYTES);

   phase_type       phase_ff, phase_in;
   logic [3:0]      hdr_cnt_ff, hdr_cnt_in;
   logic            q_absent_ff, q_absent_in;
   logic [5:0]      label_left_ff, label_left_in;
   logic [7:0]      chars_ff, chars_in;
   logic [2:0]      tail_cnt_ff, tail_cnt_in;
   logic [15:0]     type_ff, type_in;
   dnsq_status_type err_ff, err_in;

   logic            room;
   logic            want_char;
   logic [7:0]      char_val;
   dnsq_status_type done_status;
   dnsq_entry_type  entry;

   assign room = {1'b0, chars_ff} < CHAR_LIMIT;

   always_comb begin
      phase_in      = phase_ff;
      hdr_cnt_in    = hdr_cnt_ff;
      q_absent_in   = q_absent_ff;
      label_left_in = label_left_ff;
      chars_in      = chars_ff;
      tail_cnt_in   = tail_cnt_ff;
      type_in       = type_ff;
      err_in        = err_ff;
      want_char     = 1'b0;
      char_val      = CHAR_DOT;
      done_status   = ST_OK;

      case (phase_ff)
         PH_HEADER: begin
            if (hdr_cnt_ff == 4'd4) begin
               q_absent_in = (data_byte == 8'd0);
            end else if (hdr_cnt_ff == 4'd5 && data_byte != 8'd0) begin
               q_absent_in = 1'b0;
            end
            hdr_cnt_in = hdr_cnt_ff + 4'd1;
            if (hdr_cnt_in >= HDR_LAST) begin
               if (q_absent_in) begin
                  err_in   = ST_NOQ;
                  phase_in = PH_DRAIN;
               end else begin
                  phase_in = PH_LENGTH;
               end
            end
         end
         PH_LENGTH: begin
            if (data_byte == 8'd0) begin
               if (chars_ff == 8'd0) begin
                  err_in   = ST_EMPTY;
                  phase_in = PH_DRAIN;
               end else begin
                  phase_in    = PH_TAIL;
                  tail_cnt_in = 3'd0;
               end
            end else if ((data_byte & LABEL_PTR_MASK) != 8'd0) begin
               err_in   = ST_COMP;
               phase_in = PH_DRAIN;
            end else begin
               // dot goes ahead of every label but the first
               if (chars_ff != 8'd0) begin
                  want_char = room;
                  char_val  = CHAR_DOT;
               end
               label_left_in = data_byte[5:0];
               phase_in      = PH_LABEL;
            end
         end
         PH_LABEL: begin
            want_char = room;
            char_val  = (data_byte >= PRINT_LOW && data_byte <= PRINT_HIGH) ?
                        data_byte : CHAR_QUESTION;
            label_left_in = label_left_ff - 6'd1;
            if (label_left_in == 6'd0) begin
               phase_in = PH_LENGTH;
            end
         end
         PH_TAIL: begin
            if (tail_cnt_ff < 3'd2) begin
               type_in = {type_ff[7:0], data_byte};
            end
            tail_cnt_in = tail_cnt_ff + 3'd1;
            if (tail_cnt_in >= TAIL_BYTES) begin
               phase_in = PH_DONE;
            end
         end
         default: begin
         end
      endcase

      if (want_char) begin
         chars_in = chars_ff + 8'd1;
      end

      case (phase_in)
         PH_HEADER: done_status = ST_SHORT;
         PH_LENGTH: done_status = (chars_in == 8'd0) ? ST_EMPTY : ST_NOTAIL;
         PH_LABEL:  done_status = ST_OVERRUN;
         PH_TAIL:   done_status = ST_NOTAIL;
         PH_DONE:   done_status = ST_OK;
         default:   done_status = err_in;
      endcase

      entry.has_char    = want_char;
      entry.name_char   = char_val;
      entry.has_done    = end_of_packet;
      entry.status      = done_status;
      entry.query_type  = (done_status == ST_OK) ? type_in : 16'd0;
      entry.name_length = chars_in;
   end

   assign push       = byte_valid && (want_char || end_of_packet);
   assign push_entry = entry;

   always_ff @(posedge clock) begin
      if (reset || (byte_valid && end_of_packet)) begin
         phase_ff      <= PH_HEADER;
         hdr_cnt_ff    <= 4'd0;
         q_absent_ff   <= 1'b1;
         label_left_ff <= 6'd0;
         chars_ff      <= 8'd0;
         tail_cnt_ff   <= 3'd0;
         type_ff       <= 16'd0;
         err_ff        <= ST_OK;
      end else if (byte_valid) begin
         phase_ff      <= phase_in;
         hdr_cnt_ff    <= hdr_cnt_in;
         q_absent_ff   <= q_absent_in;
         label_left_ff <= label_left_in;
         chars_ff      <= chars_in;
         tail_cnt_ff   <= tail_cnt_in;
         type_ff       <= type_in;
         err_ff        <= err_in;
      end
   end

endmodule

[design/dnsq_queue.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// DNS question parser work queue
// Small register FIFO between the byte classifier and the formatter.
// ---------------------------------------------------------------------------
module dnsq_queue #(
   parameter int DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  dnsq_pkg::dnsq_entry_type push_entry,
   input  logic                     pop,
   output logic                     full,
   output logic                     not_empty,
   output dnsq_pkg::dnsq_entry_type head_entry
);
   import dnsq_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   dnsq_entry_type   slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_pop;

   assign full       = (count_ff == CNT_FULL);
   assign not_empty  = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];
   assign do_pop     = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      case ({push, do_pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[design/dnsq_back.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// DNS question parser back end
// Turns queue entries into result transfers through an output register,
// character first when an entry also completes the packet.
// ---------------------------------------------------------------------------
module dnsq_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     head_valid,
   input  dnsq_pkg::dnsq_entry_type head_entry,
   output logic                     pop,
   output logic                     out_valid,
   input  logic                     out_ready,
   output logic                     out_kind,
   output logic [7:0]               out_char,
   output logic [15:0]              out_qtype,
   output logic [2:0]               out_status,
   output logic [7:0]               out_length,
   output logic                     out_last
);
   import dnsq_pkg::*;

   logic        valid_ff;
   logic        char_sent_ff;
   logic        kind_ff;
   logic [7:0]  char_ff;
   logic [15:0] qtype_ff;
   logic [2:0]  status_ff;
   logic [7:0]  length_ff;
   logic        last_ff;

   logic        load;
   logic        send_char;

   assign load      = head_valid && (!valid_ff || out_ready);
   assign send_char = head_entry.has_char && !char_sent_ff;
   // hold the entry while its completion is still to go
   assign pop       = load && !(send_char && head_entry.has_done);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         char_sent_ff <= 1'b0;
      end else begin
         if (load) begin
            valid_ff     <= 1'b1;
            char_sent_ff <= send_char && head_entry.has_done;
         end else if (out_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         if (send_char) begin
            kind_ff   <= KIND_CHAR;
            char_ff   <= head_entry.name_char;
            qtype_ff  <= 16'd0;
            status_ff <= ST_OK;
            length_ff <= 8'd0;
            last_ff   <= 1'b0;
         end else begin
            kind_ff   <= KIND_DONE;
            char_ff   <= 8'd0;
            qtype_ff  <= head_entry.query_type;
            status_ff <= head_entry.status;
            length_ff <= head_entry.name_length;
            last_ff   <= 1'b1;
         end
      end
   end

   assign out_valid  = valid_ff;
   assign out_kind   = kind_ff;
   assign out_char   = char_ff;
   assign out_qtype  = qtype_ff;
   assign out_status = status_ff;
   assign out_length = length_ff;
   assign out_last   = last_ff;

endmodule

[tb/dns_question_name_parser_core_test.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// DNS question name parser core testbench
// Streams directed and random query packets into the parser, predicts every
// name character and completion in a scoreboard, and compares each response
// transfer field by field, with random stalls on both streams.
// ---------------------------------------------------------------------------
module dns_question_name_parser_core_test;
   import dnsq_pkg::*;

   localparam int NAME_CAPACITY  = dnsq_pkg::NAME_CAPACITY_DEFAULT;
   localparam int ITEM_TARGET    = 640;    // bytes sent over the whole run
   localparam int CALM_BYTES     = 580;    // bytes sent before idling stops
   localparam int WATCHDOG_LIMIT = 2000;   // cycles with no transfer on either side
   localparam int DRAIN_CYCLES   = 8;      // settle time for strays after the last result

   typedef enum logic [2:0] {
      PH_HEADER, PH_LENGTH, PH_LABEL, PH_TAIL, PH_DONE, PH_DRAIN
   } parse_phase_type;

   // One response transfer as the parser should produce it
   typedef struct {
      dnsq_kind_type   kind;
      logic [7:0]      name_char;
      logic [15:0]     query_type;
      dnsq_status_type status;
      logic [7:0]      name_length;
      logic            last;
   } name_item_type;

   // ------------------------------------------------------------------------
   // Scoreboard: walks each accepted byte through its own copy of the parse
   // state and queues the characters and completions it should produce.
   // ------------------------------------------------------------------------
   class name_scoreboard;
      parse_phase_type phase;
      logic [3:0]      hdr_count;
      logic            no_question;
      logic [5:0]      label_left;
      logic [7:0]      chars_out;
      logic [2:0]      tail_count;
      logic [15:0]     qtype;
      dnsq_status_type err_code;
      name_item_type   name_items_q[$];
      int              mismatches;
      int              bytes_in;
      int              packets;
      int              chars_checked;
      int              status_count[7];

      function new();
         mismatches    = 0;
         bytes_in      = 0;
         packets       = 0;
         chars_checked = 0;
         foreach (status_count[i]) status_count[i] = 0;
         restart();
      endfunction

      function void restart();
         phase       = PH_HEADER;
         hdr_count   = '0;
         no_question = 1'b1;
         label_left  = '0;
         chars_out   = '0;
         tail_count  = '0;
         qtype       = '0;
         err_code    = ST_OK;
      endfunction

      function int pending();
         return name_items_q.size();
      endfunction

      // Queue a character unless the name is already full; drop it silently
      function void push_char(logic [7:0] c);
         name_item_type it;
         if (int'(chars_out) < NAME_CAPACITY - 1) begin
            it.kind        = KIND_CHAR;
            it.name_char   = c;
            it.query_type  = '0;
            it.status      = ST_OK;
            it.name_length = '0;
            it.last        = 1'b0;
            name_items_q.push_back(it);
            chars_out = chars_out + 8'd1;
         end
      endfunction

      function void abort(dnsq_status_type code);
         err_code = code;
         phase    = PH_DRAIN;
      endfunction

      function void note_byte(logic [7:0] b, logic eop);
         name_item_type   it;
         dnsq_status_type st;
         bytes_in++;
         case (phase)
            PH_HEADER: begin
               // question count sits in header bytes 4 and 5
               if (hdr_count == 4'd4)
                  no_question = (b == 8'h00);
               else if (hdr_count == 4'd5 && b != 8'h00)
                  no_question = 1'b0;
               hdr_count = hdr_count + 4'd1;
               if (int'(hdr_count) >= HEADER_BYTES) begin
                  if (no_question)
                     abort(ST_NOQ);
                  else
                     phase = PH_LENGTH;
               end
            end
            PH_LENGTH: begin
               if (b == 8'h00) begin
                  if (chars_out == 8'd0) begin
                     abort(ST_EMPTY);
                  end else begin
                     phase      = PH_TAIL;
                     tail_count = '0;
                  end
               end else if ((b & LABEL_PTR_MASK) != 8'h00) begin
                  abort(ST_COMP);
               end else begin
                  if (chars_out != 8'd0) push_char(CHAR_DOT);
                  label_left = b[5:0];
                  phase      = PH_LABEL;
               end
            end
            PH_LABEL: begin
               push_char((b >= PRINT_LOW && b <= PRINT_HIGH) ? b : CHAR_QUESTION);
               label_left = label_left - 6'd1;
               if (label_left == 6'd0) phase = PH_LENGTH;
            end
            PH_TAIL: begin
               if (tail_count < 3'd2) qtype = {qtype[7:0], b};
               tail_count = tail_count + 3'd1;
               if (tail_count >= TAIL_BYTES) phase = PH_DONE;
            end
            default: ;
         endcase

         if (eop) begin
            case (phase)
               PH_HEADER: st = ST_SHORT;
               PH_LENGTH: st = (chars_out == 8'd0) ? ST_EMPTY : ST_NOTAIL;
               PH_LABEL:  st = ST_OVERRUN;
               PH_TAIL:   st = ST_NOTAIL;
               PH_DONE:   st = ST_OK;
               default:   st = err_code;
            endcase
            it.kind        = KIND_DONE;
            it.name_char   = '0;
            it.query_type  = (st == ST_OK) ? qtype : 16'h0000;
            it.status      = st;
            it.name_length = chars_out;
            it.last        = 1'b1;
            name_items_q.push_back(it);
            status_count[int'(st)]++;
            packets++;
            restart();
         end
      endfunction

      task report_mismatch(string msg);
         $display("[%0t] mismatch: %s", $realtime, msg);
         mismatches++;
      endtask

      task check_result(logic kind, logic [39:0] data, logic last);
         name_item_type want;
         if (name_items_q.size() == 0) begin
            report_mismatch($sformatf("unexpected transfer kind %0d data %h", kind, data));
         end else begin
            want = name_items_q.pop_front();
            if (kind !== want.kind)
               report_mismatch($sformatf("kind exp %0d got %0d", want.kind, kind));
            if (data[7:0] !== want.name_char)
               report_mismatch($sformatf("name_char exp %h got %h", want.name_char,
                                         data[7:0]));
            if (data[23:8] !== want.query_type)
               report_mismatch($sformatf("query_type exp %h got %h", want.query_type,
                                         data[23:8]));
            if (data[26:24] !== want.status)
               report_mismatch($sformatf("status exp %0d got %0d", want.status,
                                         data[26:24]));
            if (data[34:27] !== want.name_length)
               report_mismatch($sformatf("name_length exp %0d got %0d", want.name_length,
                                         data[34:27]));
            if (data[39:35] !== 5'd0)
               report_mismatch($sformatf("padding bits set: %b", data[39:35]));
            if (last !== want.last)
               report_mismatch($sformatf("tlast exp %0d got %0d", want.last, last));
            if (want.kind == KIND_CHAR) chars_checked++;
         end
      endtask
   endclass

   // ------------------------------------------------------------------------
   // Clock, reset and DUT
   // ------------------------------------------------------------------------
   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // [7:0] data_byte
   logic        req_tlast  = 1'b0;    // end_of_packet
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;            // [7:0] name_char, [23:8] query_type,
                                      // [26:24] parse_status, [34:27] name_length
   logic        rsp_tuser;            // [0] item_kind
   logic        rsp_tlast;            // run_last

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   dns_question_name_parser_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   name_scoreboard board = new();

   logic        calm  = 1'b0;   // set near the end: no idling on either side
   logic        quiet = 1'b0;   // per packet: sender sends back to back
   logic [7:0]  pkt[$];         // packet under construction
   int          stall_left = 0;
   int          run_left   = 0;
   int          idle_cycles = 0;

   // ------------------------------------------------------------------------
   // Response side: ready drops for random stalls between runs of varying
   // length; hold it high once the run is calm.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (calm) begin
         rsp_tready <= 1'b1;
      end else if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= 1'b1;
         if (run_left != 0)
            run_left--;
         else if ($urandom_range(0, 2) == 0)
            stall_left = $urandom_range(1, 17);
         else
            run_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150)
                                                   : $urandom_range(1, 20);
      end
   end

   // Check every response transfer as it happens
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_result(rsp_tuser, rsp_tdata, rsp_tlast);
   end

   // Watchdog: end the run if nothing moves for too long
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                     idle_cycles, board.pending());
            $display("FAIL");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Packet building
   // ------------------------------------------------------------------------

   // Twelve header bytes; question count bytes are given, the rest random
   function automatic void add_header(logic [7:0] qd_hi, logic [7:0] qd_lo);
      for (int i = 0; i < HEADER_BYTES; i++) begin
         if (i == 4)
            pkt.push_back(qd_hi);
         else if (i == 5)
            pkt.push_back(qd_lo);
         else
            pkt.push_back(8'($urandom));
      end
   endfunction

   function automatic void add_label(int len, bit printable);
      pkt.push_back(8'(len));
      for (int i = 0; i < len; i++)
         pkt.push_back(printable ? 8'($urandom_range(8'h20, 8'h7E)) : 8'($urandom));
   endfunction

   // Big-endian query type, then two random class bytes
   function automatic void add_tail(logic [15:0] qt);
      pkt.push_back(qt[15:8]);
      pkt.push_back(qt[7:0]);
      pkt.push_back(8'($urandom));
      pkt.push_back(8'($urandom));
   endfunction

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------

   // Present one byte, optionally after an idle gap, and hold it until taken
   task automatic send_byte(logic [7:0] b, logic eop, int gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= eop;
      do @(posedge clock); while (!req_tready);
      board.note_byte(b, eop);
   endtask

   task automatic send_packet();
      int gap;
      for (int i = 0; i < pkt.size(); i++) begin
         gap = 0;
         if (!calm && !quiet && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 17);
         send_byte(pkt[i], i == pkt.size() - 1, gap);
      end
      pkt.delete();
   endtask

   // Hold the sender until every predicted result has been seen
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
   endtask

   // One random packet: mostly well formed with random content, some broken
   task automatic send_random_packet();
      int  pick;
      int  labels;
      int  cut;
      pick  = $urandom_range(0, 99);
      quiet = ($urandom_range(0, 4) == 0);
      if (pick < 10) begin
         // noise: arbitrary bytes of arbitrary length
         repeat ($urandom_range(1, 24)) pkt.push_back(8'($urandom));
      end else begin
         if (pick < 18)
            add_header(8'h00, 8'h00);
         else if ($urandom_range(0, 1) == 0)
            add_header(8'h00, 8'($urandom_range(1, 255)));
         else
            add_header(8'($urandom_range(1, 255)), 8'($urandom));
         labels = $urandom_range(1, 4);
         for (int i = 0; i < labels; i++)
            add_label(($urandom_range(0, 9) == 0) ? $urandom_range(11, 63)
                                                  : $urandom_range(1, 10),
                      $urandom_range(0, 3) != 0);
         if (pick < 28) begin
            // pointer or reserved label type in place of the terminator
            pkt.push_back({2'($urandom_range(1, 3)), 6'($urandom)});
            repeat ($urandom_range(0, 4)) pkt.push_back(8'($urandom));
         end else begin
            pkt.push_back(8'h00);
            add_tail(16'($urandom));
            if ($urandom_range(0, 2) == 0)
               repeat ($urandom_range(1, 3)) pkt.push_back(8'($urandom));
         end
         if ($urandom_range(0, 4) == 0) begin
            // truncate anywhere, header included
            cut = $urandom_range(1, pkt.size());
            while (pkt.size() > cut) void'(pkt.pop_back());
         end
      end
      send_packet();
      quiet = 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Minimal good query: one-character name, type A
      add_header(8'h00, 8'h01);
      add_label(1, 1'b1);
      pkt.push_back(8'h00);
      add_tail(16'h0001);
      send_packet();

      // High count byte only, max qtype, trailing bytes ignored
      add_header(8'h01, 8'h00);
      add_label(10, 1'b1);
      add_label(1, 1'b1);
      pkt.push_back(8'h00);
      add_tail(16'hFFFF);
      pkt.push_back(8'hA5);
      pkt.push_back(8'h5A);
      send_packet();

      // Printable range edges and unprintable bytes in one label
      add_header(8'hFF, 8'hFF);
      pkt.push_back(8'd8);
      pkt.push_back(8'h00);
      pkt.push_back(8'h1F);
      pkt.push_back(8'h20);
      pkt.push_back(8'h7E);
      pkt.push_back(8'h7F);
      pkt.push_back(8'h80);
      pkt.push_back(8'hFF);
      pkt.push_back(8'h41);
      pkt.push_back(8'h00);
      add_tail(16'h0000);
      send_packet();

      // Short header: single byte, and one byte short of a full header
      pkt.push_back(8'h00);
      send_packet();
      add_header(8'h00, 8'h01);
      void'(pkt.pop_back());
      send_packet();

      // Zero question count, with trailing bytes and ending right on the header
      add_header(8'h00, 8'h00);
      add_label(3, 1'b1);
      send_packet();
      add_header(8'h00, 8'h00);
      send_packet();

      // Empty name: packet ends after the header, or terminator comes first
      add_header(8'h00, 8'h01);
      send_packet();
      add_header(8'h00, 8'h01);
      pkt.push_back(8'h00);
      add_tail(16'h001C);
      send_packet();

      // Compressed pointer up front; reserved label types after a label
      add_header(8'h00, 8'h02);
      pkt.push_back(8'hC0);
      pkt.push_back(8'h0C);
      add_tail(16'h0001);
      send_packet();
      add_header(8'h00, 8'h01);
      add_label(3, 1'b1);
      pkt.push_back(8'h40);
      pkt.push_back(8'h00);
      send_packet();
      add_header(8'h00, 8'h01);
      add_label(2, 1'b1);
      pkt.push_back(8'h80);
      send_packet();

      // Packet ends inside a label, and right after a length byte
      add_header(8'h00, 8'h01);
      add_label(5, 1'b1);
      void'(pkt.pop_back());
      void'(pkt.pop_back());
      void'(pkt.pop_back());
      send_packet();
      add_header(8'h00, 8'h01);
      pkt.push_back(8'd4);
      send_packet();

      // Missing type or class: after a full label, at the terminator, two bytes in
      add_header(8'h00, 8'h01);
      add_label(2, 1'b1);
      add_label(3, 1'b1);
      send_packet();
      add_header(8'h00, 8'h01);
      add_label(4, 1'b1);
      pkt.push_back(8'h00);
      send_packet();
      add_header(8'h00, 8'h01);
      add_label(4, 1'b1);
      pkt.push_back(8'h00);
      pkt.push_back(8'h00);
      pkt.push_back(8'h0F);
      send_packet();

      // Pause: let every predicted result come back before going on
      wait_for_drain();

      // Name fills exactly to the 255-character limit with longest labels, then one more
      // label is dropped while the parse still completes
      add_header(8'h00, 8'h01);
      repeat (4) add_label(63, 1'b1);
      add_label(2, 1'b0);
      pkt.push_back(8'h00);
      add_tail(16'h00FF);
      send_packet();

      // Random packets; drop all idling for the last stretch
      while (board.bytes_in < ITEM_TARGET) begin
         if (board.bytes_in >= CALM_BYTES) calm = 1'b1;
         send_random_packet();
         if (!calm && $urandom_range(0, 29) == 0) wait_for_drain();
      end
      req_tvalid <= 1'b0;

      // Wait out the outstanding results, then keep watching for strays
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d bytes in %0d packets, %0d name characters checked.",
               board.bytes_in, board.packets, board.chars_checked);
      $display("Status mix ok/short/noq/comp/overrun/empty/notail: %0d/%0d/%0d/%0d/%0d/%0d/%0d",
               board.status_count[0], board.status_count[1], board.status_count[2],
               board.status_count[3], board.status_count[4], board.status_count[5],
               board.status_count[6]);
      if (board.mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("%0d mismatches", board.mismatches);
         $display("FAIL");
      end
      $finish;
   end

endmodule
